@@ rtl/gsa_pkg.sv @@
// gsa_pkg: shared types, codes and constants of the guarded slot allocator
// no dependencies; used by every module under rtl

package gsa_pkg;

    // slot and bitmap sizing; the bitmap rotation works modulo SLOT_COUNT
    localparam int SLOT_COUNT = 64;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int CNT_W      = SLOT_W + 1;

    // field widths
    localparam int ADDR_W     = 48;
    localparam int SIZE_W     = 21;
    localparam int RAND_W     = 64;
    localparam int SHIFT_W    = 5;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_IDX_W  = 2;

    // page size limits
    localparam logic [SHIFT_W-1:0] PAGE_SHIFT_MIN = SHIFT_W'(12);
    localparam logic [SHIFT_W-1:0] PAGE_SHIFT_MAX = SHIFT_W'(20);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_SHIFT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_PAGE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOC_ALLOW  = 2'd3;

    typedef enum logic [1:0] {
        MODE_ALLOC = 2'd0,
        MODE_FREE  = 2'd1,
        MODE_FAULT = 2'd2,
        MODE_SIZE  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_REFUSED = 2'd1,
        STATUS_OUTSIDE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FAULT_UNKNOWN   = 2'd0,
        FAULT_USE_FREED = 2'd1,
        FAULT_UNDERFLOW = 2'd2,
        FAULT_OVERFLOW  = 2'd3
    } fault_t;

    // request beat
    typedef struct packed {
        mode_t               mode;
        logic [RAND_W-1:0]   random_word;
        logic [SIZE_W-1:0]   request_size;
        logic [ADDR_W-1:0]   address;
    } req_t;

    // response beat
    typedef struct packed {
        status_t             status;
        logic [ADDR_W-1:0]   page_address;
        logic [SLOT_W-1:0]   slot_index;
        fault_t              fault_kind;
        logic [SIZE_W-1:0]   stored_size;
    } rsp_t;

    // effective configuration seen by the datapath
    typedef struct packed {
        logic [CNT_W-1:0]      slots;
        logic [SHIFT_W-1:0]    shift;
        logic [ADDR_W-1:0]     base;
        logic [ADDR_W-1:0]     page_mask;
        logic                  allow;
        logic                  reload;
        logic [SLOT_COUNT-1:0] reload_map;
    } cfg_t;

    // slot pick result
    typedef struct packed {
        logic              any;
        logic [SLOT_W-1:0] slot;
    } pick_t;

    // address decode result
    typedef struct packed {
        logic              page_ok;
        logic [SLOT_W-1:0] page_slot;
        logic              fault_in_range;
        logic [SLOT_W-1:0] fault_slot;
        logic              below_base;
        logic              upper_half;
    } map_t;

    // index of the single set bit of a one-hot word
    function automatic logic [SLOT_W-1:0] onehot_index(input logic [SLOT_COUNT-1:0] oh);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (oh[i])
            begin
                idx = idx | SLOT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/gsa_cfg_regs.sv @@
// gsa_cfg_regs: configuration registers with range clamping on write
// depends on gsa_pkg

module gsa_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [gsa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gsa_pkg::CFG_DATA_W-1:0]   cfg_data,
    output gsa_pkg::cfg_t                    cfg
);

    logic [gsa_pkg::CNT_W-1:0]   slots_reg;
    logic [gsa_pkg::CNT_W-1:0]   slots_next;
    logic [gsa_pkg::SHIFT_W-1:0] shift_reg;
    logic [gsa_pkg::SHIFT_W-1:0] shift_next;
    logic [gsa_pkg::ADDR_W-1:0]  first_reg;
    logic                        allow_reg;
    logic [gsa_pkg::CNT_W-1:0]   wr_slots;
    logic [gsa_pkg::SHIFT_W-1:0] wr_shift;

    // clamp the written values to their legal ranges
    always_comb
    begin
        wr_slots = cfg_data[gsa_pkg::CNT_W-1:0];
        if (wr_slots == '0)
        begin
            wr_slots = gsa_pkg::CNT_W'(1);
        end
        else if (wr_slots > gsa_pkg::CNT_W'(gsa_pkg::SLOT_COUNT))
        begin
            wr_slots = gsa_pkg::CNT_W'(gsa_pkg::SLOT_COUNT);
        end

        wr_shift = cfg_data[gsa_pkg::SHIFT_W-1:0];
        if (wr_shift < gsa_pkg::PAGE_SHIFT_MIN)
        begin
            wr_shift = gsa_pkg::PAGE_SHIFT_MIN;
        end
        else if (wr_shift > gsa_pkg::PAGE_SHIFT_MAX)
        begin
            wr_shift = gsa_pkg::PAGE_SHIFT_MAX;
        end
    end

    assign slots_next = (cfg_write && cfg_index == gsa_pkg::REG_SLOTS_IN_USE)
                        ? wr_slots : slots_reg;
    assign shift_next = (cfg_write && cfg_index == gsa_pkg::REG_PAGE_SHIFT)
                        ? wr_shift : shift_reg;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= gsa_pkg::CNT_W'(gsa_pkg::SLOT_COUNT);
            shift_reg <= gsa_pkg::PAGE_SHIFT_MIN;
            first_reg <= '0;
            allow_reg <= 1'b0;
        end
        else
        begin
            slots_reg <= slots_next;
            shift_reg <= shift_next;
            if (cfg_write && cfg_index == gsa_pkg::REG_FIRST_PAGE)
            begin
                first_reg <= cfg_data[gsa_pkg::ADDR_W-1:0];
            end
            if (cfg_write && cfg_index == gsa_pkg::REG_ALLOC_ALLOW)
            begin
                allow_reg <= cfg_data[0];
            end
        end
    end

    // effective view plus bitmap reload on a slot count write
    always_comb
    begin
        cfg.slots      = slots_reg;
        cfg.shift      = shift_reg;
        cfg.page_mask  = (gsa_pkg::ADDR_W'(1) << shift_reg) - gsa_pkg::ADDR_W'(1);
        cfg.base       = first_reg & ~cfg.page_mask;
        cfg.allow      = allow_reg;
        cfg.reload     = cfg_write && cfg_index == gsa_pkg::REG_SLOTS_IN_USE;
        for (int i = 0; i < gsa_pkg::SLOT_COUNT; i++)
        begin
            cfg.reload_map[i] = gsa_pkg::CNT_W'(i) < wr_slots;
        end
    end

endmodule

@@ rtl/gsa_slot_pick.sv @@
// gsa_slot_pick: rotates the free bitmap and picks the lowest free bit
// depends on gsa_pkg

module gsa_slot_pick (
    input  logic [gsa_pkg::SLOT_COUNT-1:0] free_map,
    input  logic [gsa_pkg::SLOT_W-1:0]     rot,
    output gsa_pkg::pick_t                 pick
);

    logic [2*gsa_pkg::SLOT_COUNT-1:0] dbl;
    logic [gsa_pkg::SLOT_COUNT-1:0]   rotated;
    logic [gsa_pkg::SLOT_COUNT-1:0]   lowest;
    logic [gsa_pkg::SLOT_W-1:0]       low_idx;

    // rotate left, isolate the lowest set bit, map back to the slot
    assign dbl     = {free_map, free_map} << rot;
    assign rotated = dbl[2*gsa_pkg::SLOT_COUNT-1:gsa_pkg::SLOT_COUNT];
    assign lowest  = rotated & (~rotated + gsa_pkg::SLOT_COUNT'(1));
    assign low_idx = gsa_pkg::onehot_index(lowest);

    assign pick.any  = |free_map;
    assign pick.slot = low_idx - rot;

endmodule

@@ rtl/gsa_addr_map.sv @@
// gsa_addr_map: maps addresses to slots for free, size query and fault query
// depends on gsa_pkg

module gsa_addr_map (
    input  gsa_pkg::cfg_t                cfg,
    input  logic [gsa_pkg::ADDR_W-1:0]   address,
    output gsa_pkg::map_t                map
);

    localparam int WIDE_W = gsa_pkg::ADDR_W + 1;
    localparam int IDX_W  = gsa_pkg::CNT_W + 1;

    logic [gsa_pkg::ADDR_W-1:0] off;
    logic [gsa_pkg::ADDR_W-1:0] idx;
    logic [gsa_pkg::ADDR_W-1:0] half_bits;
    logic [WIDE_W-1:0]          base_w;
    logic [WIDE_W-1:0]          addr_w;
    logic [WIDE_W-1:0]          page_w;
    logic [WIDE_W-1:0]          lo;
    logic [WIDE_W-1:0]          hi;
    logic [IDX_W-1:0]           idx_n;
    logic [IDX_W-1:0]           near;
    logic [IDX_W-1:0]           last;

    // offset from the first page and page index
    assign off       = address - cfg.base;
    assign idx       = off >> cfg.shift;
    assign half_bits = off >> (cfg.shift - gsa_pkg::SHIFT_W'(1));

    assign map.below_base = address < cfg.base;
    assign map.upper_half = half_bits[0];

    // start of a usable page of a slot in use
    assign map.page_ok   = !map.below_base
                           && ((off & cfg.page_mask) == '0)
                           && !idx[0]
                           && ((idx >> 1) < gsa_pkg::ADDR_W'(cfg.slots));
    assign map.page_slot = idx[gsa_pkg::SLOT_W:1];

    // fault window: one guard page below the first page up to the last guard page
    assign base_w = {1'b0, cfg.base};
    assign addr_w = {1'b0, address};
    assign page_w = WIDE_W'(1) << cfg.shift;
    assign lo     = (base_w >= page_w) ? base_w - page_w : '0;
    assign hi     = base_w + ((WIDE_W'(cfg.slots) << cfg.shift) << 1);

    assign map.fault_in_range = !(addr_w < lo) && (addr_w < hi);

    // nearest slot: guard pages split at their half
    assign idx_n = {1'b0, idx[gsa_pkg::CNT_W-1:0]};
    assign last  = IDX_W'(cfg.slots) - IDX_W'(1);

    always_comb
    begin
        if (map.below_base)
        begin
            near = '0;
        end
        else if (!idx_n[0])
        begin
            near = idx_n >> 1;
        end
        else if (!map.upper_half)
        begin
            near = (idx_n - IDX_W'(1)) >> 1;
        end
        else
        begin
            near = (idx_n + IDX_W'(1)) >> 1;
        end
        if (near > last)
        begin
            near = last;
        end
    end

    assign map.fault_slot = near[gsa_pkg::SLOT_W-1:0];

endmodule

@@ rtl/guarded_slot_allocator.sv @@
// guarded_slot_allocator: request register, one pass of decode and update, response register
// throughput: one request per cycle, limited only by response back-pressure
// reset: bitmap holds all slots free, live and freed flags clear, config at defaults
// the stored size memory is not cleared; a size query on a never-allocated slot reads junk
// depends on gsa_pkg, gsa_cfg_regs, gsa_slot_pick, gsa_addr_map

module guarded_slot_allocator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [gsa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [gsa_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  gsa_pkg::req_t                    req,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output gsa_pkg::rsp_t                    rsp
);

    gsa_pkg::cfg_t  cfg;
    gsa_pkg::pick_t pick;
    gsa_pkg::map_t  map;

    logic                           s1_valid_reg;
    logic                           s1_valid_next;
    gsa_pkg::req_t                  s1_req_reg;
    logic                           rsp_valid_reg;
    logic                           rsp_valid_next;
    gsa_pkg::rsp_t                  rsp_reg;
    gsa_pkg::rsp_t                  rsp_next;
    logic                           size_sel_reg;
    logic                           size_sel_next;
    logic [gsa_pkg::SIZE_W-1:0]     size_rd_reg;
    logic [gsa_pkg::SLOT_COUNT-1:0] free_map_reg;
    logic [gsa_pkg::SLOT_COUNT-1:0] free_map_next;
    logic [gsa_pkg::SLOT_COUNT-1:0] live_reg;
    logic [gsa_pkg::SLOT_COUNT-1:0] live_next;
    logic [gsa_pkg::SLOT_COUNT-1:0] freed_reg;
    logic [gsa_pkg::SLOT_COUNT-1:0] freed_next;
    logic [gsa_pkg::SIZE_W-1:0]     size_mem [gsa_pkg::SLOT_COUNT];

    logic                           adv;
    logic                           alloc_ok;
    logic                           free_ok;
    logic [gsa_pkg::SIZE_W-1:0]     page_size;
    logic [gsa_pkg::SIZE_W-1:0]     req_sat;

    gsa_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gsa_slot_pick u_pick (
        .free_map (free_map_reg),
        .rot      (s1_req_reg.random_word[gsa_pkg::SLOT_W-1:0]),
        .pick     (pick)
    );

    gsa_addr_map u_map (
        .cfg     (cfg),
        .address (s1_req_reg.address),
        .map     (map)
    );

    // handshake: the request stage moves on when the response register is empty or its beat is taken
    assign adv            = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready      = !s1_valid_reg || adv;
    assign s1_valid_next  = (req_valid && req_ready) || (s1_valid_reg && !adv);
    assign rsp_valid_next = adv || (rsp_valid_reg && !rsp_ready);

    // size saturated to one page
    assign page_size = gsa_pkg::SIZE_W'(1) << cfg.shift;
    assign req_sat   = (s1_req_reg.request_size > page_size) ? page_size
                                                             : s1_req_reg.request_size;

    // response and decision for the item in the request stage
    always_comb
    begin
        rsp_next.status       = gsa_pkg::STATUS_OK;
        rsp_next.page_address = '0;
        rsp_next.slot_index   = '0;
        rsp_next.fault_kind   = gsa_pkg::FAULT_UNKNOWN;
        rsp_next.stored_size  = '0;
        alloc_ok              = 1'b0;
        free_ok               = 1'b0;
        size_sel_next         = 1'b0;

        unique case (s1_req_reg.mode)
            gsa_pkg::MODE_ALLOC:
            begin
                if (!cfg.allow || cfg.base == '0 || !pick.any)
                begin
                    rsp_next.status = gsa_pkg::STATUS_REFUSED;
                end
                else
                begin
                    alloc_ok              = 1'b1;
                    rsp_next.slot_index   = pick.slot;
                    rsp_next.page_address = cfg.base
                        + ((gsa_pkg::ADDR_W'(pick.slot) << cfg.shift) << 1);
                    rsp_next.stored_size  = req_sat;
                end
            end
            gsa_pkg::MODE_FREE:
            begin
                if (!map.page_ok)
                begin
                    rsp_next.status = gsa_pkg::STATUS_OUTSIDE;
                end
                else
                begin
                    free_ok             = 1'b1;
                    rsp_next.slot_index = map.page_slot;
                end
            end
            gsa_pkg::MODE_SIZE:
            begin
                if (!map.page_ok)
                begin
                    rsp_next.status = gsa_pkg::STATUS_OUTSIDE;
                end
                else
                begin
                    size_sel_next       = 1'b1;
                    rsp_next.slot_index = map.page_slot;
                end
            end
            gsa_pkg::MODE_FAULT:
            begin
                if (!map.fault_in_range)
                begin
                    rsp_next.status = gsa_pkg::STATUS_OUTSIDE;
                end
                else
                begin
                    rsp_next.slot_index = map.fault_slot;
                    if (!live_reg[map.fault_slot])
                    begin
                        rsp_next.fault_kind = gsa_pkg::FAULT_UNKNOWN;
                    end
                    else if (freed_reg[map.fault_slot])
                    begin
                        rsp_next.fault_kind = gsa_pkg::FAULT_USE_FREED;
                    end
                    else if (map.below_base || map.upper_half)
                    begin
                        rsp_next.fault_kind = gsa_pkg::FAULT_UNDERFLOW;
                    end
                    else
                    begin
                        rsp_next.fault_kind = gsa_pkg::FAULT_OVERFLOW;
                    end
                end
            end
            default:
            begin
                rsp_next.status = gsa_pkg::STATUS_OK;
            end
        endcase
    end

    // slot state update
    always_comb
    begin
        free_map_next = free_map_reg;
        live_next     = live_reg;
        freed_next    = freed_reg;
        priority if (cfg.reload)
        begin
            free_map_next = cfg.reload_map;
        end
        else if (adv && alloc_ok)
        begin
            free_map_next[pick.slot] = 1'b0;
            live_next[pick.slot]     = 1'b1;
            freed_next[pick.slot]    = 1'b0;
        end
        else if (adv && free_ok)
        begin
            free_map_next[map.page_slot] = 1'b1;
            freed_next[map.page_slot]    = 1'b1;
        end
    end

    // control and slot state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            size_sel_reg  <= 1'b0;
            free_map_reg  <= '1;
            live_reg      <= '0;
            freed_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (adv)
            begin
                size_sel_reg <= size_sel_next;
            end
            free_map_reg  <= free_map_next;
            live_reg      <= live_next;
            freed_reg     <= freed_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_req_reg <= req;
        end
        if (adv)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // stored size memory: at most one write and one registered read per cycle, only when the request stage moves on
    always_ff @(posedge clk)
    begin
        if (adv && alloc_ok)
        begin
            size_mem[pick.slot] <= req_sat;
        end
        if (adv)
        begin
            size_rd_reg <= size_mem[map.page_slot];
        end
    end

    // response beat
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        rsp = rsp_reg;
        if (size_sel_reg)
        begin
            rsp.stored_size = size_rd_reg;
        end
    end

endmodule
